FILE: src/dsu_pkg.sv
`default_nettype none

package dsu_pkg;

    // Field widths on the stream ports
    localparam int ELEM_FIELD_W = 10;
    localparam int SIZE_FIELD_W = 11;
    localparam int S_TDATA_W    = 24;
    localparam int S_TUSER_W    = 1;
    localparam int M_TDATA_W    = 24;
    localparam int M_PAD_W      = M_TDATA_W - (ELEM_FIELD_W + 1 + SIZE_FIELD_W);

    // Request kinds carried on tuser
    typedef enum logic {
        REQ_FIND  = 1'b0,
        REQ_UNION = 1'b1
    } t_req_kind;

    // Controller to datapath commands
    typedef struct packed {
        logic in_ready;   // idle, take a request beat
        logic load_req;   // latch request, point cursor at first element
        logic clr_write;  // write one cleared entry, advance sweep
        logic rd_cur;     // read the entry under the cursor
        logic step_walk;  // move cursor to the parent just read
        logic found;      // record root and size, rewind cursor to path start
        logic comp_step;  // rewrite cursor entry to root, move to old parent
        logic next_b;     // save first root, point cursor at second element
        logic link_lose;  // hang smaller root under larger
        logic link_win;   // write summed size into surviving root
        logic load_out;   // fill the output register
    } t_dsu_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic q_is_root;    // entry just read is a root
        logic cur_is_root;  // cursor reached the recorded root
        logic roots_equal;  // both union operands share one root
        logic clr_last;     // sweep at the final entry
        logic is_union;     // latched request is a union
        logic out_free;     // output register can take a result
    } t_dsu_sts;

endpackage

`default_nettype wire

FILE: src/disjoint_set_union_find.sv
// A find walks the links of an element to its root, then points each entry on the path at
// the root; a union runs both finds and, unless they share one root, links the two roots.
// One request at a time: the next beat can be taken in the cycle after the result is
// loaded. A link read takes a read and a check state; a path rewrite, a read and a write.
// A result waits in the output register while the next request runs; a full, stalled
// register holds the block. Reset: synchronous, active low, then a sweep clears the table.
`default_nettype none

module disjoint_set_union_find
    import dsu_pkg::*;
#(
    parameter int ELEMENTS = 1024
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,   // first_element, second_element
    input  wire logic [S_TUSER_W-1:0] s_axis_tuser,   // req_type
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0]      m_axis_tdata    // root, merged, set_size
);

    t_dsu_cmd w_cmd;
    t_dsu_sts w_sts;

    dsu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    dsu_datapath #(
        .ELEMENTS (ELEMENTS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata)
    );

    assign s_axis_tready = w_cmd.in_ready;

`ifndef SYNTHESIS
    // One request at a time: an accepted beat closes the input
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while another is in work");

    // The clearing sweep follows reset with the input closed
    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !s_axis_tready)
        else $error("input open before the link table is cleared");

    // A result is loaded only while the input is closed
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> !s_axis_tready)
        else $error("result loaded while idle");
`endif

endmodule

`default_nettype wire

FILE: src/dsu_datapath.sv
`default_nettype none

module dsu_datapath
    import dsu_pkg::*;
#(
    parameter int ELEMENTS = 1024
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_dsu_cmd             i_cmd,
    output t_dsu_sts                  o_sts,
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,   // first_element, second_element
    input  wire logic [S_TUSER_W-1:0] i_s_tuser,   // req_type
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic [M_TDATA_W-1:0]      o_m_tdata    // root, merged, set_size
);

    localparam int IDX_W  = $clog2(ELEMENTS);
    localparam int SIZE_W = $clog2(ELEMENTS + 1);
    localparam int ENT_W  = SIZE_W + 1;   // root flag over size or parent

    // Link table: root flag, then size (root) or parent index (link)
    logic [ENT_W-1:0]     r_mem [ELEMENTS];
    logic [ENT_W-1:0]     r_q;

    logic [IDX_W-1:0]     r_b;
    logic                 r_kind;
    logic [IDX_W-1:0]     r_start;
    logic [IDX_W-1:0]     r_cur;
    logic [IDX_W-1:0]     r_root;
    logic [SIZE_W-1:0]    r_size;
    logic [IDX_W-1:0]     r_ra;
    logic [SIZE_W-1:0]    r_sa;
    logic                 r_merged;
    logic [IDX_W-1:0]     r_clr;
    logic                 r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;

    logic [IDX_W-1:0]     w_first;
    logic [IDX_W-1:0]     w_second;
    logic [IDX_W-1:0]     w_q_parent;
    logic [SIZE_W-1:0]    w_q_size;
    logic [IDX_W-1:0]     w_winner;
    logic [IDX_W-1:0]     w_loser;
    logic [SIZE_W-1:0]    w_sum;
    logic                 w_wr_en;
    logic [IDX_W-1:0]     w_wr_addr;
    logic [ENT_W-1:0]     w_wr_data;

    // Saturate an out-of-range element index to the last element
    function automatic logic [IDX_W-1:0] clamp_idx(input logic [ELEM_FIELD_W-1:0] v);
        if (32'(v) >= ELEMENTS) begin
            return IDX_W'(ELEMENTS - 1);
        end
        return IDX_W'(v);
    endfunction

    assign w_first    = clamp_idx(i_s_tdata[ELEM_FIELD_W-1:0]);
    assign w_second   = clamp_idx(i_s_tdata[2*ELEM_FIELD_W-1:ELEM_FIELD_W]);
    assign w_q_size   = r_q[SIZE_W-1:0];
    assign w_q_parent = w_q_size[IDX_W-1:0];

    // Smaller set loses; on a tie the first root stays
    assign w_winner = (r_sa < r_size) ? r_root : r_ra;
    assign w_loser  = (r_sa < r_size) ? r_ra : r_root;
    assign w_sum    = r_sa + r_size;

    // Select the single write of this cycle
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_cur;
        w_wr_data = '0;
        if (i_cmd.clr_write) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_clr;
            w_wr_data = {1'b1, SIZE_W'(1)};
        end else if (i_cmd.comp_step) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_cur;
            w_wr_data = {1'b0, SIZE_W'(r_root)};
        end else if (i_cmd.link_lose) begin
            w_wr_en   = 1'b1;
            w_wr_addr = w_loser;
            w_wr_data = {1'b0, SIZE_W'(w_winner)};
        end else if (i_cmd.link_win) begin
            w_wr_en   = 1'b1;
            w_wr_addr = w_winner;
            w_wr_data = {1'b1, w_sum};
        end
    end

    // Link table port: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (i_cmd.rd_cur) begin
            r_q <= r_mem[r_cur];
        end
    end

    // Cursor, roots and request payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_b     <= w_second;
            r_kind  <= i_s_tuser[0];
            r_cur   <= w_first;
            r_start <= w_first;
        end else if (i_cmd.step_walk) begin
            r_cur <= w_q_parent;
        end else if (i_cmd.found) begin
            r_root <= r_cur;
            r_size <= w_q_size;
            r_cur  <= r_start;
        end else if (i_cmd.comp_step) begin
            r_cur <= w_q_parent;
        end else if (i_cmd.next_b) begin
            r_ra    <= r_root;
            r_sa    <= r_size;
            r_cur   <= r_b;
            r_start <= r_b;
        end else if (i_cmd.link_win) begin
            r_root <= w_winner;
            r_size <= w_sum;
        end
    end

    // Clearing sweep, merge flag and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_merged    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_write) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.load_req) begin
                r_merged <= 1'b0;
            end else if (i_cmd.link_win) begin
                r_merged <= 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data <= {M_PAD_W'(0), SIZE_FIELD_W'(r_size), r_merged,
                           ELEM_FIELD_W'(r_root)};
        end
    end

    assign o_sts.q_is_root   = r_q[SIZE_W];
    assign o_sts.cur_is_root = (r_cur == r_root);
    assign o_sts.roots_equal = (r_ra == r_root);
    assign o_sts.clr_last    = (r_clr == IDX_W'(ELEMENTS - 1));
    assign o_sts.is_union    = (t_req_kind'(r_kind) == REQ_UNION);
    assign o_sts.out_free    = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

`default_nettype wire

FILE: src/dsu_ctrl.sv
`default_nettype none

module dsu_ctrl
    import dsu_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_s_tvalid,
    input  wire t_dsu_sts i_sts,
    output t_dsu_cmd      o_cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK_RD,
        ST_WALK_CHK,
        ST_COMP_TEST,
        ST_COMP_CHK,
        ST_LINK_LOSE,
        ST_LINK_WIN,
        ST_RESULT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_phase_b;
    logic   n_phase_b;

    // Decode commands and next state
    always_comb begin
        o_cmd     = '0;
        n_state   = r_state;
        n_phase_b = r_phase_b;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_write = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load_req = 1'b1;
                    n_phase_b      = 1'b0;
                    n_state        = ST_WALK_RD;
                end
            end
            ST_WALK_RD: begin
                o_cmd.rd_cur = 1'b1;
                n_state      = ST_WALK_CHK;
            end
            ST_WALK_CHK: begin
                if (i_sts.q_is_root) begin
                    o_cmd.found = 1'b1;
                    n_state     = ST_COMP_TEST;
                end else begin
                    o_cmd.step_walk = 1'b1;
                    n_state         = ST_WALK_RD;
                end
            end
            ST_COMP_TEST: begin
                if (!i_sts.cur_is_root) begin
                    o_cmd.rd_cur = 1'b1;
                    n_state      = ST_COMP_CHK;
                end else if (!i_sts.is_union) begin
                    n_state = ST_RESULT;
                end else if (!r_phase_b) begin
                    o_cmd.next_b = 1'b1;
                    n_phase_b    = 1'b1;
                    n_state      = ST_WALK_RD;
                end else if (i_sts.roots_equal) begin
                    n_state = ST_RESULT;
                end else begin
                    n_state = ST_LINK_LOSE;
                end
            end
            ST_COMP_CHK: begin
                o_cmd.comp_step = 1'b1;
                n_state         = ST_COMP_TEST;
            end
            ST_LINK_LOSE: begin
                o_cmd.link_lose = 1'b1;
                n_state         = ST_LINK_WIN;
            end
            ST_LINK_WIN: begin
                o_cmd.link_win = 1'b1;
                n_state        = ST_RESULT;
            end
            ST_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_phase_b <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase_b <= n_phase_b;
        end
    end

endmodule

`default_nettype wire

FILE: tb/sv/tb_disjoint_set_union_find.sv
`timescale 1ns / 100ps

module tb_disjoint_set_union_find
    import dsu_pkg::*;
();

    localparam int NUM_ELEMENTS  = 1024;
    localparam int RANDOM_ITEMS  = 1600;
    localparam int STALL_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 200;
    localparam int REPORT_LIMIT  = 10;

    // One answer beat: root, merged flag, size of the root's set
    typedef struct packed {
        logic [ELEM_FIELD_W-1:0] root;
        logic                    merged;
        logic [SIZE_FIELD_W-1:0] set_total;
    } t_dsu_answer;

    // Shadow forest plus the queue of answers still owed by the block
    class dsu_scoreboard;
        bit [ELEM_FIELD_W-1:0] link_up   [NUM_ELEMENTS];
        bit [SIZE_FIELD_W-1:0] set_total [NUM_ELEMENTS];
        bit                    is_head   [NUM_ELEMENTS];
        t_dsu_answer           expected_answers [$];
        int failures;
        int finds;
        int unions;
        int merges;
        int answers_checked;
        int largest_set;

        function new();
            for (int k = 0; k < NUM_ELEMENTS; k++) begin
                link_up[k]   = ELEM_FIELD_W'(k);
                set_total[k] = SIZE_FIELD_W'(1);
                is_head[k]   = 1'b1;
            end
            failures        = 0;
            finds           = 0;
            unions          = 0;
            merges          = 0;
            answers_checked = 0;
            largest_set     = 1;
        endfunction

        // Walk to the root, then point every node on the path straight at it
        function bit [ELEM_FIELD_W-1:0] find_head(bit [ELEM_FIELD_W-1:0] elem);
            bit [ELEM_FIELD_W-1:0] head;
            bit [ELEM_FIELD_W-1:0] cur;
            bit [ELEM_FIELD_W-1:0] nxt;
            head = elem;
            while (!is_head[head])
                head = link_up[head];
            cur = elem;
            while (cur != head) begin
                nxt          = link_up[cur];
                link_up[cur] = head;
                cur          = nxt;
            end
            return head;
        endfunction

        function void note_request(t_req_kind kind, bit [ELEM_FIELD_W-1:0] first_elem,
                                   bit [ELEM_FIELD_W-1:0] second_elem);
            t_dsu_answer           ans;
            bit [ELEM_FIELD_W-1:0] root_a;
            bit [ELEM_FIELD_W-1:0] root_b;
            bit [ELEM_FIELD_W-1:0] swap;
            ans.merged = 1'b0;
            root_a     = find_head(first_elem);
            if (kind == REQ_UNION) begin
                unions++;
                root_b = find_head(second_elem);
                if (root_a != root_b) begin
                    // hang the smaller set under the larger; ties keep the first root
                    if (set_total[root_a] < set_total[root_b]) begin
                        swap   = root_a;
                        root_a = root_b;
                        root_b = swap;
                    end
                    set_total[root_a] += set_total[root_b];
                    link_up[root_b]    = root_a;
                    is_head[root_b]    = 1'b0;
                    ans.merged         = 1'b1;
                    merges++;
                    if (set_total[root_a] > largest_set)
                        largest_set = int'(set_total[root_a]);
                end
            end else begin
                finds++;
            end
            ans.root      = root_a;
            ans.set_total = set_total[root_a];
            expected_answers.insert(expected_answers.size(), ans);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] beat);
            t_dsu_answer             want;
            logic [ELEM_FIELD_W-1:0] got_root;
            logic                    got_merged;
            logic [SIZE_FIELD_W-1:0] got_total;
            got_root   = beat[ELEM_FIELD_W-1:0];
            got_merged = beat[ELEM_FIELD_W];
            got_total  = beat[ELEM_FIELD_W+SIZE_FIELD_W:ELEM_FIELD_W+1];
            if (expected_answers.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("ERROR: unexpected result beat: root=%0d merged=%0d size=%0d",
                             got_root, got_merged, got_total);
                return;
            end
            want = expected_answers.pop_front();
            answers_checked++;
            if (got_root !== want.root || got_merged !== want.merged ||
                got_total !== want.set_total) begin
                failures++;
                if (failures <= REPORT_LIMIT) begin
                    $display("ERROR: answer %0d: expected root=%0d merged=%0d size=%0d",
                             answers_checked, want.root, want.merged, want.set_total);
                    $display("       got root=%0d merged=%0d size=%0d",
                             got_root, got_merged, got_total);
                end
            end
        endfunction

        function int pending();
            return expected_answers.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;    // first_element, second_element
    logic [S_TUSER_W-1:0] s_axis_tuser;    // req_type
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;    // root, merged, set_size

    dsu_scoreboard forest_sb;
    int            burst_left;
    int            ready_left;
    int            quiet_cycles;

    disjoint_set_union_find #(
        .ELEMENTS(NUM_ELEMENTS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Record request beats and check answer beats on the rising edge
    always @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready)
            forest_sb.note_request(t_req_kind'(s_axis_tuser[0]),
                                   s_axis_tdata[ELEM_FIELD_W-1:0],
                                   s_axis_tdata[2*ELEM_FIELD_W-1:ELEM_FIELD_W]);
        if (m_axis_tvalid && m_axis_tready)
            forest_sb.check_result(m_axis_tdata);
    end

    // Watchdog: end the run when neither side moves a beat for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("ERROR: no beat moved for %0d cycles, %0d answers pending",
                     STALL_LIMIT, forest_sb.pending());
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver: a random mix of ready runs and stalls of random length
    always @(negedge i_clk) begin
        if (ready_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                m_axis_tready <= 1'b1;
                ready_left    <= $urandom_range(1, 40);
            end else begin
                m_axis_tready <= 1'b0;
                ready_left    <= $urandom_range(1, 12);
            end
        end else begin
            ready_left <= ready_left - 1;
        end
    end

    // Present one request beat, hold it until taken, then pace the next burst
    task automatic send_request(input t_req_kind kind, input logic [ELEM_FIELD_W-1:0] first_elem,
                                input logic [ELEM_FIELD_W-1:0] second_elem);
        int gap;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W - 2*ELEM_FIELD_W){1'b0}}, second_elem, first_elem};
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            gap        = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                s_axis_tdata  <= S_TDATA_W'($urandom);
                s_axis_tuser  <= S_TUSER_W'($urandom_range(0, 1));
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    // Mostly the whole range, often a dense low window, sometimes the top end
    function automatic logic [ELEM_FIELD_W-1:0] pick_element();
        case ($urandom_range(0, 3))
            0, 1:    return ELEM_FIELD_W'($urandom_range(0, NUM_ELEMENTS - 1));
            2:       return ELEM_FIELD_W'($urandom_range(0, 127));
            default: return ELEM_FIELD_W'(NUM_ELEMENTS - 1 - $urandom_range(0, 31));
        endcase
    endfunction

    initial begin
        t_req_kind kind;
        forest_sb     = new();
        burst_left    = 0;
        ready_left    = 0;
        quiet_cycles  = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Extremes on a fresh forest; the second element of a find is ignored
        send_request(REQ_FIND,  10'd0,    10'd1023);
        send_request(REQ_FIND,  10'd1023, 10'd0);
        // equal sizes keep the first root
        send_request(REQ_UNION, 10'd0,    10'd1023);
        // union inside one set
        send_request(REQ_UNION, 10'd1023, 10'd0);
        send_request(REQ_UNION, 10'd5,    10'd5);
        // the smaller set hangs under the larger, first or second
        send_request(REQ_UNION, 10'd1,    10'd2);
        send_request(REQ_UNION, 10'd3,    10'd1);
        send_request(REQ_UNION, 10'd1,    10'd0);
        // build a three-link path from element 11 to its root, then find it twice
        send_request(REQ_UNION, 10'd10,   10'd11);
        send_request(REQ_UNION, 10'd12,   10'd13);
        send_request(REQ_UNION, 10'd12,   10'd10);
        send_request(REQ_UNION, 10'd14,   10'd15);
        send_request(REQ_UNION, 10'd16,   10'd17);
        send_request(REQ_UNION, 10'd16,   10'd14);
        send_request(REQ_UNION, 10'd16,   10'd12);
        send_request(REQ_FIND,  10'd11,   10'd682);
        send_request(REQ_FIND,  10'd11,   10'd341);
        // alternating bit patterns on both element fields
        send_request(REQ_UNION, 10'd682,  10'd341);
        send_request(REQ_FIND,  10'd341,  10'd682);
        send_request(REQ_UNION, 10'd1023, 10'd5);
        send_request(REQ_UNION, 10'd16,   10'd1023);

        // Random mix of finds and unions
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            kind = ($urandom_range(0, 99) < 55) ? REQ_UNION : REQ_FIND;
            send_request(kind, pick_element(), pick_element());
        end

        // Drop valid and drain the answers still owed
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (forest_sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d finds and %0d unions, %0d of which merged two sets",
                 forest_sb.finds, forest_sb.unions, forest_sb.merges);
        $display("Checked %0d answers; largest set reached %0d elements",
                 forest_sb.answers_checked, forest_sb.largest_set);
        if (forest_sb.failures == 0 && forest_sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d failures, %0d answers never arrived",
                     forest_sb.failures, forest_sb.pending());
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/dsu_pkg.sv
src/dsu_datapath.sv
src/dsu_ctrl.sv
src/disjoint_set_union_find.sv
tb/sv/tb_disjoint_set_union_find.sv
